@@ rtl/ihex_pkg.sv @@
// Shared types and constants of the Intel HEX record encoder.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    localparam int FILL_W    = 5;   // byte count of one record, 0..16
    localparam int DIGIT_W   = 5;   // character index inside one record field
    localparam int EOF_CHARS = 12;  // ":00000001FF" and the newline

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] REC_TYPE_DAT = 8'h00;

    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // Field of the text that the current character belongs to
    typedef enum logic [2:0] {
        FLD_COLON,
        FLD_LEN,
        FLD_ADDR,
        FLD_TYPE,
        FLD_DATA,
        FLD_SUM,
        FLD_NL,
        FLD_EOF
    } field_t;

    // Controller to datapath
    typedef struct packed {
        logic   emit;          // load one character into the output register
        field_t field;
        digit_t digit;         // character index inside the field
        logic   last;          // last character caused by the input transfer
        logic   store;         // write the input byte into the record buffer
        logic   clear_rec;     // record sent: empty the buffer
        logic   clear_stream;  // end of file: restart at offset zero
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  emit_ok;        // output register free or draining this cycle
        logic  empty;          // no byte in the buffer
        logic  full_next;      // a stored byte completes the record
        fill_t fill;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/intel_hex_record_encoder_core.sv @@
// Top level of the Intel HEX record encoder.
`timescale 1ns / 1ps
`default_nettype none

// Turns a byte stream into Intel HEX text, one ASCII character per output
// transfer. A data byte that does not complete a record is only stored.
// The byte that completes a record of RECORD_BYTES bytes is followed by the
// record text, 12 + 2*RECORD_BYTES characters; a finish transfer is followed
// by the partial record (12 + 2*n characters, none when empty) and then the
// 12-character end-of-file record. One character leaves per cycle through the
// single output register when the output side does not stall, and input is
// taken again the cycle after the last character is loaded. Addresses wrap
// at 64 KiB and a finish restarts the stream at address zero.
module intel_hex_record_encoder_core #(
    parameter int RECORD_BYTES = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      text_char,
    output logic            run_last
);
    import ihex_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ihex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ihex_dp #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .text_char (text_char),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

@@ rtl/ihex_dp.sv @@
// Datapath: record buffer, offsets, checksum and the output character register.
`timescale 1ns / 1ps
`default_nettype none

module ihex_dp #(
    parameter int RECORD_BYTES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         data_byte,
    input  wire ihex_pkg::dp_cmd_t  cmd,
    output ihex_pkg::dp_stat_t      stat,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [7:0]              text_char,
    output logic                    run_last
);
    import ihex_pkg::*;

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic [7:0]  rec_mem [RECORD_BYTES];

    fill_t       fill_reg, fill_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  dsum_reg, dsum_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  text_char_reg;
    logic        run_last_reg;
    logic [7:0]  rd_byte_reg;

    fill_t            fill_plus;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       sum_all;
    logic [7:0]       csum;
    logic [7:0]       field_byte;
    logic [3:0]       nibble;
    logic [7:0]       char_next;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
            c = 8'h30 + {4'h0, v};
        else
            c = 8'h37 + {4'h0, v};
        return c;
    endfunction

    function automatic logic [7:0] eof_char(input digit_t idx);
        logic [7:0] c;
        case (idx) inside
            5'd0:         c = CHAR_COLON;
            [5'd1:5'd7]:  c = 8'h30;
            5'd8:         c = 8'h31;
            5'd9, 5'd10:  c = 8'h46;
            default:      c = CHAR_NL;
        endcase
        return c;
    endfunction

    assign fill_plus = fill_reg + fill_t'(1);

    assign stat.emit_ok   = !out_valid_reg || out_ready;
    assign stat.empty     = (fill_reg == '0);
    assign stat.full_next = (fill_plus >= fill_t'(RECORD_BYTES));
    assign stat.fill      = fill_reg;

    // Two characters per byte: even index is the high nibble. Fetch the byte
    // for the character that follows, so it is registered before it is needed.
    assign rd_idx = (cmd.field == FLD_DATA)
                  ? cmd.digit[IDX_W:1] + IDX_W'(cmd.digit[0] & cmd.emit)
                  : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            rec_mem[fill_reg[IDX_W-1:0]] <= data_byte;
        rd_byte_reg <= rec_mem[rd_idx];
    end

    assign sum_all = {3'b000, fill_reg} + addr_reg[15:8] + addr_reg[7:0] + dsum_reg;
    assign csum    = 8'h00 - sum_all;

    always_comb
    begin
        case (cmd.field)
            FLD_LEN:  field_byte = {3'b000, fill_reg};
            FLD_ADDR: field_byte = cmd.digit[1] ? addr_reg[7:0] : addr_reg[15:8];
            FLD_TYPE: field_byte = REC_TYPE_DAT;
            FLD_DATA: field_byte = rd_byte_reg;
            FLD_SUM:  field_byte = csum;
            default:  field_byte = 8'h00;
        endcase
        nibble = cmd.digit[0] ? field_byte[3:0] : field_byte[7:4];
        case (cmd.field)
            FLD_COLON: char_next = CHAR_COLON;
            FLD_NL:    char_next = CHAR_NL;
            FLD_EOF:   char_next = eof_char(cmd.digit);
            default:   char_next = hex_char(nibble);
        endcase
    end

    always_comb
    begin
        fill_next   = fill_reg;
        offset_next = offset_reg;
        addr_next   = addr_reg;
        dsum_next   = dsum_reg;
        if (cmd.clear_stream)
        begin
            fill_next   = '0;
            offset_next = '0;
            addr_next   = '0;
            dsum_next   = '0;
        end
        else if (cmd.clear_rec)
        begin
            fill_next = '0;
            dsum_next = '0;
        end
        else if (cmd.store)
        begin
            if (fill_reg == '0)
                addr_next = offset_reg;
            fill_next   = fill_plus;
            offset_next = offset_reg + 16'd1;
            dsum_next   = dsum_reg + data_byte;
        end

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            offset_reg    <= '0;
            addr_reg      <= '0;
            dsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            offset_reg    <= offset_next;
            addr_reg      <= addr_next;
            dsum_reg      <= dsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            text_char_reg <= char_next;
            run_last_reg  <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign run_last  = run_last_reg;

`ifndef SYNTHESIS
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("character loaded over a pending transfer");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fill_t'(RECORD_BYTES))
        else $error("record buffer overfilled");
`endif

endmodule

`default_nettype wire

@@ rtl/ihex_ctrl.sv @@
// Controller: walks the fields of a data record and of the end-of-file record.
`timescale 1ns / 1ps
`default_nettype none

module ihex_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               action,
    output logic                    in_ready,
    output ihex_pkg::dp_cmd_t       cmd,
    input  wire ihex_pkg::dp_stat_t stat
);
    import ihex_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLON,
        ST_LEN,
        ST_ADDR,
        ST_TYPE,
        ST_DATA,
        ST_SUM,
        ST_NL,
        ST_EOF
    } state_t;

    state_t           state_reg, state_next;
    state_t           follow;
    digit_t           digit_reg, digit_next;
    logic             fin_reg, fin_next;
    digit_t           digit_max;
    logic             digit_done;
    logic [DIGIT_W:0] data_digits;
    logic             accept;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign data_digits = {stat.fill, 1'b0} - (DIGIT_W+1)'(1);

    always_comb
    begin
        case (state_reg)
            ST_LEN, ST_TYPE, ST_SUM: digit_max = digit_t'(1);
            ST_ADDR:                 digit_max = digit_t'(3);
            ST_DATA:                 digit_max = data_digits[DIGIT_W-1:0];
            ST_EOF:                  digit_max = digit_t'(EOF_CHARS - 1);
            default:                 digit_max = '0;
        endcase
    end

    assign digit_done = (digit_reg == digit_max);

    always_comb
    begin
        state_next = state_reg;
        digit_next = digit_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.field  = FLD_COLON;
        cmd.digit  = digit_reg;
        follow     = ST_IDLE;

        case (state_reg)
            ST_COLON: begin cmd.field = FLD_COLON; follow = ST_LEN;  end
            ST_LEN:   begin cmd.field = FLD_LEN;   follow = ST_ADDR; end
            ST_ADDR:  begin cmd.field = FLD_ADDR;  follow = ST_TYPE; end
            ST_TYPE:  begin cmd.field = FLD_TYPE;  follow = ST_DATA; end
            ST_DATA:  begin cmd.field = FLD_DATA;  follow = ST_SUM;  end
            ST_SUM:   begin cmd.field = FLD_SUM;   follow = ST_NL;   end
            ST_NL:
            begin
                cmd.field = FLD_NL;
                cmd.last  = !fin_reg;
                follow    = fin_reg ? ST_EOF : ST_IDLE;
            end
            ST_EOF:
            begin
                cmd.field = FLD_EOF;
                cmd.last  = digit_done;
                follow    = ST_IDLE;
            end
            default:  begin cmd.field = FLD_COLON; follow = ST_IDLE; end
        endcase

        if (state_reg == ST_IDLE)
        begin
            digit_next = '0;
            if (accept)
            begin
                if (!action)
                begin
                    cmd.store = 1'b1;
                    if (stat.full_next)
                    begin
                        fin_next   = 1'b0;
                        state_next = ST_COLON;
                    end
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = stat.empty ? ST_EOF : ST_COLON;
                end
            end
        end
        else
        begin
            // Advance one character per free output slot
            cmd.emit = stat.emit_ok;
            if (stat.emit_ok)
            begin
                if (digit_done)
                begin
                    digit_next       = '0;
                    state_next       = follow;
                    cmd.clear_rec    = (state_reg == ST_NL);
                    cmd.clear_stream = (state_reg == ST_EOF);
                end
                else
                begin
                    digit_next = digit_reg + digit_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            digit_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            digit_reg <= digit_next;
            fin_reg   <= fin_next;
        end
    end

`ifndef SYNTHESIS
    a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action) |=> !in_ready)
        else $error("finish transfer did not start the end-of-file record");

    a_data_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> !stat.empty)
        else $error("data field entered with an empty record buffer");
`endif

endmodule

`default_nettype wire

@@ tb/sv/intel_hex_record_encoder_core_tb.sv @@
// Testbench of the Intel HEX record encoder: byte streams against a predictor.
`timescale 1ns / 1ps

module intel_hex_record_encoder_core_tb;

    import ihex_pkg::*;

    localparam int  RECORD_BYTES = 16;
    localparam int  CYCLE_LIMIT  = 200_000;
    localparam int  DRAIN_CYCLES = 32;
    localparam int  REPORT_MAX   = 10;
    localparam int  PHASE_ITEMS  = 82;

    localparam logic ACT_DATA   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_exp_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       action = ACT_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] text_char;
    logic       run_last;

    // Predictor state
    logic [7:0]  rec_buf [RECORD_BYTES];
    fill_t       rec_fill;
    logic [15:0] stream_pos;
    logic [15:0] rec_start;

    text_exp_t   exp_text [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int chars_checked  = 0;
    int items_sent     = 0;
    int finishes_sent  = 0;
    int records_seen   = 0;

    intel_hex_record_encoder_core #(
        .RECORD_BYTES(RECORD_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .text_char(text_char),
        .run_last (run_last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still expected",
                     cycle_count, exp_text.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib - 4'd10);
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        text_exp_t e;
        e.ch   = ch;
        e.last = 1'b0;
        exp_text.push_back(e);
    endfunction

    function automatic void push_hex(input logic [7:0] v);
        push_char(hex_char(v[7:4]));
        push_char(hex_char(v[3:0]));
    endfunction

    function automatic void push_record();
        logic [7:0] sum;
        sum = 8'(rec_fill) + rec_start[15:8] + rec_start[7:0] + REC_TYPE_DAT;
        push_char(CHAR_COLON);
        push_hex(8'(rec_fill));
        push_hex(rec_start[15:8]);
        push_hex(rec_start[7:0]);
        push_hex(REC_TYPE_DAT);
        for (int i = 0; i < int'(rec_fill); i++)
        begin
            sum += rec_buf[i];
            push_hex(rec_buf[i]);
        end
        push_hex(8'(-sum));
        push_char(CHAR_NL);
        rec_fill = '0;
        records_seen++;
    endfunction

    // Predict the text that one accepted transfer causes
    function automatic void encode_item(input logic act, input logic [7:0] b);
        string     eof_text;
        int        before_cnt;
        text_exp_t tail;
        eof_text   = ":00000001FF";
        before_cnt = exp_text.size();
        if (act == ACT_DATA)
        begin
            if (rec_fill == 0)
                rec_start = stream_pos;
            rec_buf[rec_fill[3:0]] = b;
            rec_fill++;
            stream_pos++;
            if (int'(rec_fill) >= RECORD_BYTES)
                push_record();
        end
        else
        begin
            if (rec_fill != 0)
                push_record();
            for (int i = 0; i < eof_text.len(); i++)
                push_char(eof_text[i]);
            push_char(CHAR_NL);
            rec_fill   = '0;
            stream_pos = '0;
            rec_start  = '0;
        end
        // Flag the final character of this run
        if (exp_text.size() > before_cnt)
        begin
            tail      = exp_text.pop_back();
            tail.last = 1'b1;
            exp_text.push_back(tail);
        end
    endfunction

    function automatic void report_mismatch(input string what,
                                            input logic [8:0] want,
                                            input logic [8:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("Mismatch %0d at cycle %0d: %s expected %h got %h",
                     mismatches, cycle_count, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        text_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            chars_checked++;
            if (exp_text.size() == 0)
                report_mismatch("unexpected char/last", 9'h0, {text_char, run_last});
            else
            begin
                e = exp_text.pop_front();
                if (text_char !== e.ch)
                    report_mismatch("text_char", {1'b0, e.ch}, {1'b0, text_char});
                if (run_last !== e.last)
                    report_mismatch("run_last", {8'h0, e.last}, {8'h0, run_last});
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        action    = act;
        data_byte = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_item(act, b);
        items_sent++;
        if (act == ACT_FINISH)
            finishes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (exp_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_finish();
        // Data bits must be ignored on a finish
        send_item(ACT_FINISH, 8'hA5);
    endtask

    task automatic test_single_byte_flush();
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_FINISH, 8'h00);
    endtask

    task automatic test_full_record();
        logic [7:0] b;
        for (int i = 0; i < RECORD_BYTES; i++)
        begin
            if (i == 0)
                b = 8'h00;
            else if (i == 1)
                b = 8'hFF;
            else
                b = {4'(i), ~4'(i)};
            send_item(ACT_DATA, b);
        end
        // Buffer is empty here: EOF only
        send_item(ACT_FINISH, 8'hFF);
    endtask

    task automatic test_partial_record();
        send_item(ACT_DATA, 8'h80);
        send_item(ACT_DATA, 8'h01);
        send_item(ACT_DATA, 8'h7F);
        send_item(ACT_FINISH, 8'h5A);
    endtask

    task automatic test_random_stream(input int gap_pct, input int stall_pct);
        logic act;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            act = ($urandom_range(17) == 0) ? ACT_FINISH : ACT_DATA;
            send_item(act, 8'($urandom));
        end
    endtask

    initial
    begin
        rec_fill   = '0;
        stream_pos = '0;
        rec_start  = '0;
        for (int i = 0; i < RECORD_BYTES; i++)
            rec_buf[i] = 8'h00;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_empty_finish();
        test_single_byte_flush();
        test_full_record();
        test_partial_record();

        test_random_stream(0, 0);
        test_random_stream(45, 0);
        test_random_stream(0, 45);
        test_random_stream(27, 27);

        wait_drained();

        $display("Sent %0d transfers (%0d finish), checked %0d characters in %0d records",
                 items_sent, finishes_sent, chars_checked, records_seen);
        $display("Covered full and partial records, empty finish, four idle mixes");
        if (mismatches == 0 && exp_text.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d characters never seen", mismatches, exp_text.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
